>>> src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and codes of the record stream indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    // input actions
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_START = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_RECORD  = 3'd0;
    localparam logic [2:0] KIND_UNKNOWN = 3'd1;
    localparam logic [2:0] KIND_TRUNC   = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ID_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_DATA_START  = 2'd1;
    localparam logic [1:0] CFG_DATA_LENGTH = 2'd2;

    // bytes in a variable-length prefix
    localparam logic [47:0] LEN_BYTES = 48'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [7:0]  entry_id;
        logic [31:0] entry_size;
        logic        entry_variable;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  record_id;
        logic [47:0] payload_offset;
        logic [31:0] payload_size;
        logic [47:0] id_total_bytes;
        logic [31:0] id_record_count;
        logic        block_end;
    } t_out_item;

    // operations from the parser to the statistics stage
    typedef enum logic [1:0] {
        OP_PASS,
        OP_RECORD,
        OP_QUERY
    } t_op_code;

    typedef struct packed {
        t_op_code    code;
        logic [2:0]  kind;
        logic [7:0]  id;
        logic        in_range;
        logic [47:0] offset;
        logic [31:0] size;
        logic        last;
    } t_op;

endpackage

`default_nettype wire

>>> src/rsi_parse.sv
// ----------------------------------------------------------------------------
// rsi_parse
// Byte parser: configuration registers, size table memory and record header
// state machine. Issues one operation per cycle while the stats stage is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_parse #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [47:0]      i_cfg_wdata,
    input  wire logic             i_in_valid,
    input  wire rsi_pkg::t_in_item i_in_data,
    output logic                  o_in_stall,
    input  wire logic             i_op_free,
    output logic                  o_op_valid,
    output rsi_pkg::t_op          o_op,
    output logic                  o_clr
);

    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_SKIP
    } t_phase;

    logic [3:0]  r_id_length;
    logic [47:0] r_data_start;
    logic [47:0] r_data_length;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_id_lo, n_id_lo;
    logic        r_id_up, n_id_up;
    logic [31:0] r_len_acc, n_len_acc;
    logic [31:0] r_skip, n_skip;
    logic [47:0] r_pos, n_pos;
    logic        r_err, n_err;
    logic        r_pend, n_pend;
    logic        r_pend_last, n_pend_last;
    logic [7:0]  r_pend_id, n_pend_id;
    logic [47:0] r_pend_off, n_pend_off;

    // size table: variable flag and size, valid bits in flops
    logic [32:0]      sz_mem [DEPTH];
    logic [DEPTH-1:0] r_sz_vld;
    logic [32:0]      r_sz_rd;
    logic             r_sz_rd_vld;

    logic        accept;
    logic [3:0]  id_len;
    logic [7:0]  b;
    logic [47:0] pos_n;
    logic        last;
    logic [3:0]  cnt_n4;
    logic [7:0]  id_lo_n;
    logic        id_up_n;
    logic        id_done;
    logic        id_oor;
    logic [47:0] offset_id;
    logic [31:0] len_acc_n;
    logic        len_done;
    logic [31:0] skip_dec;
    logic        load_ok;
    logic        sz_rd_en;

    assign accept     = i_in_valid && i_op_free && !r_pend;
    assign o_in_stall = !i_op_free || r_pend;

    assign id_len    = (r_id_length == 4'd0) ? 4'd1 :
                       (r_id_length > 4'd8)  ? 4'd8 : r_id_length;
    assign b         = i_in_data.data_byte;
    assign pos_n     = r_pos + 48'd1;
    assign last      = (pos_n == r_data_length);
    assign cnt_n4    = {1'b0, r_cnt} + 4'd1;
    assign id_lo_n   = (r_cnt == 3'd0) ? b : r_id_lo;
    assign id_up_n   = (r_cnt == 3'd0) ? 1'b0 : (r_id_up || (b != 8'd0));
    assign id_done   = (cnt_n4 >= id_len);
    assign id_oor    = id_up_n || ({1'b0, id_lo_n} >= 9'(DEPTH));
    assign offset_id = r_data_start + pos_n;
    assign len_acc_n = r_len_acc | ({24'd0, b} << {r_cnt[1:0], 3'b000});
    assign len_done  = (r_cnt[1:0] == 2'd3);
    assign skip_dec  = (r_skip != 32'd0) ? (r_skip - 32'd1) : 32'd0;
    assign load_ok   = accept && (i_in_data.action == rsi_pkg::ACT_LOAD)
                       && ({1'b0, i_in_data.entry_id} < 9'(DEPTH));

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_id_lo     = r_id_lo;
        n_id_up     = r_id_up;
        n_len_acc   = r_len_acc;
        n_skip      = r_skip;
        n_pos       = r_pos;
        n_err       = r_err;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_pend_id   = r_pend_id;
        n_pend_off  = r_pend_off;
        o_op_valid  = 1'b0;
        o_op        = '0;
        o_clr       = 1'b0;
        sz_rd_en    = 1'b0;

        if (r_pend) begin
            // size entry of the finished identifier is now readable
            if (i_op_free) begin
                n_pend    = 1'b0;
                o_op.id   = r_pend_id;
                o_op.last = r_pend_last;
                if (!r_sz_rd_vld) begin
                    n_err       = 1'b1;
                    o_op_valid  = 1'b1;
                    o_op.code   = rsi_pkg::OP_PASS;
                    o_op.kind   = rsi_pkg::KIND_UNKNOWN;
                    o_op.offset = r_pend_off;
                end else if (r_sz_rd[32]) begin
                    n_phase   = PH_LEN;
                    n_len_acc = 32'd0;
                    if (r_pend_last) begin
                        o_op_valid = 1'b1;
                        o_op.code  = rsi_pkg::OP_PASS;
                        o_op.kind  = rsi_pkg::KIND_TRUNC;
                    end
                end else begin
                    o_op_valid    = 1'b1;
                    o_op.code     = rsi_pkg::OP_RECORD;
                    o_op.kind     = rsi_pkg::KIND_RECORD;
                    o_op.in_range = 1'b1;
                    o_op.offset   = r_pend_off;
                    o_op.size     = r_sz_rd[31:0];
                    n_skip        = r_sz_rd[31:0];
                    n_phase       = (r_sz_rd[31:0] != 32'd0) ? PH_SKIP : PH_ID;
                end
            end
        end else if (accept) begin
            case (i_in_data.action)
                rsi_pkg::ACT_BYTE: begin
                    if (!r_err && (r_pos < r_data_length)) begin
                        n_pos     = pos_n;
                        o_op.last = last;
                        o_op.code = rsi_pkg::OP_PASS;
                        case (r_phase)
                            PH_ID: begin
                                n_id_lo = id_lo_n;
                                n_id_up = id_up_n;
                                if (!id_done) begin
                                    n_cnt = cnt_n4[2:0];
                                    if (last) begin
                                        o_op_valid = 1'b1;
                                        o_op.kind  = rsi_pkg::KIND_TRUNC;
                                    end
                                end else begin
                                    n_cnt = 3'd0;
                                    if (id_oor) begin
                                        n_err       = 1'b1;
                                        o_op_valid  = 1'b1;
                                        o_op.kind   = rsi_pkg::KIND_UNKNOWN;
                                        o_op.id     = id_lo_n;
                                        o_op.offset = offset_id;
                                    end else begin
                                        n_pend      = 1'b1;
                                        n_pend_id   = id_lo_n;
                                        n_pend_last = last;
                                        n_pend_off  = offset_id;
                                        sz_rd_en    = 1'b1;
                                    end
                                end
                            end
                            PH_LEN: begin
                                n_len_acc = len_acc_n;
                                if (!len_done) begin
                                    n_cnt = cnt_n4[2:0];
                                    if (last) begin
                                        o_op_valid = 1'b1;
                                        o_op.kind  = rsi_pkg::KIND_TRUNC;
                                        o_op.id    = r_id_lo;
                                    end
                                end else begin
                                    n_cnt         = 3'd0;
                                    o_op_valid    = 1'b1;
                                    o_op.code     = rsi_pkg::OP_RECORD;
                                    o_op.kind     = rsi_pkg::KIND_RECORD;
                                    o_op.id       = r_id_lo;
                                    o_op.in_range = 1'b1;
                                    o_op.offset   = offset_id - rsi_pkg::LEN_BYTES;
                                    o_op.size     = len_acc_n;
                                    n_skip        = len_acc_n;
                                    n_phase       = (len_acc_n != 32'd0) ? PH_SKIP : PH_ID;
                                end
                            end
                            default: begin
                                n_skip = skip_dec;
                                if (skip_dec == 32'd0) begin
                                    n_phase = PH_ID;
                                end
                                if (last) begin
                                    o_op_valid = 1'b1;
                                    o_op.kind  = rsi_pkg::KIND_END;
                                end
                            end
                        endcase
                    end
                end
                rsi_pkg::ACT_QUERY: begin
                    o_op_valid    = 1'b1;
                    o_op.code     = rsi_pkg::OP_QUERY;
                    o_op.kind     = rsi_pkg::KIND_QUERY;
                    o_op.id       = i_in_data.entry_id;
                    o_op.in_range = ({1'b0, i_in_data.entry_id} < 9'(DEPTH));
                end
                rsi_pkg::ACT_START: begin
                    o_clr     = 1'b1;
                    n_phase   = PH_ID;
                    n_cnt     = 3'd0;
                    n_id_lo   = 8'd0;
                    n_id_up   = 1'b0;
                    n_len_acc = 32'd0;
                    n_skip    = 32'd0;
                    n_pos     = 48'd0;
                    n_err     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_length   <= 4'd1;
            r_data_start  <= 48'd0;
            r_data_length <= 48'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsi_pkg::CFG_ID_LENGTH:   r_id_length   <= i_cfg_wdata[3:0];
                rsi_pkg::CFG_DATA_START:  r_data_start  <= i_cfg_wdata;
                rsi_pkg::CFG_DATA_LENGTH: r_data_length <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_cnt     <= 3'd0;
            r_id_lo   <= 8'd0;
            r_id_up   <= 1'b0;
            r_len_acc <= 32'd0;
            r_skip    <= 32'd0;
            r_pos     <= 48'd0;
            r_err     <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_id_lo   <= n_id_lo;
            r_id_up   <= n_id_up;
            r_len_acc <= n_len_acc;
            r_skip    <= n_skip;
            r_pos     <= n_pos;
            r_err     <= n_err;
            r_pend    <= n_pend;
        end
        r_pend_last <= n_pend_last;
        r_pend_id   <= n_pend_id;
        r_pend_off  <= n_pend_off;
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            sz_mem[i_in_data.entry_id[AW-1:0]] <=
                {i_in_data.entry_variable, i_in_data.entry_size};
        end
        if (sz_rd_en) begin
            r_sz_rd     <= sz_mem[id_lo_n[AW-1:0]];
            r_sz_rd_vld <= r_sz_vld[id_lo_n[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sz_vld <= '0;
        end else if (load_ok) begin
            r_sz_vld[i_in_data.entry_id[AW-1:0]] <= 1'b1;
        end
    end

    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> o_in_stall)
        else $error("request accepted during size lookup");

    a_err_clears_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_err) |-> $past(accept && (i_in_data.action == rsi_pkg::ACT_START)))
        else $error("error flag cleared without start");

endmodule

`default_nettype wire

>>> src/rsi_stats.sv
// ----------------------------------------------------------------------------
// rsi_stats
// Per-identifier totals and counts: read, update with saturation, write back.
// Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_stats #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_op_valid,
    input  wire rsi_pkg::t_op   i_op,
    input  wire logic           i_clr,
    output logic                o_free,
    output logic                o_out_valid,
    output rsi_pkg::t_out_item  o_out_data,
    input  wire logic           i_out_stall
);

    logic [79:0]      st_mem [DEPTH];
    logic [DEPTH-1:0] r_st_vld;

    logic             r_s1_v;
    rsi_pkg::t_op     r_s1;
    logic [79:0]      r_rd;
    logic             r_rd_vld;
    logic             r_byp;
    logic [79:0]      r_byp_d;
    logic             r_out_v;
    rsi_pkg::t_out_item r_out;

    logic        s1_go;
    logic        take;
    logic        rd_en;
    logic        wr;
    logic [79:0] cur;
    logic        cur_v;
    logic [47:0] tot;
    logic [31:0] cnt;
    logic [48:0] sum;
    logic [47:0] tot_n;
    logic [31:0] cnt_n;
    rsi_pkg::t_out_item res;

    assign s1_go  = r_s1_v && (!r_out_v || !i_out_stall);
    assign o_free = !r_s1_v || s1_go;
    assign take   = i_op_valid && o_free;
    assign rd_en  = take && (i_op.code != rsi_pkg::OP_PASS) && i_op.in_range;
    assign wr     = s1_go && (r_s1.code == rsi_pkg::OP_RECORD);

    // entry written back in the cycle its read was issued comes from the bypass
    assign cur   = r_byp ? r_byp_d : r_rd;
    assign cur_v = r_byp || r_rd_vld;
    assign tot   = cur_v ? cur[79:32] : 48'd0;
    assign cnt   = cur_v ? cur[31:0] : 32'd0;
    assign sum   = {1'b0, tot} + {17'd0, r_s1.size};
    assign tot_n = sum[48] ? {48{1'b1}} : sum[47:0];
    assign cnt_n = (&cnt) ? cnt : (cnt + 32'd1);

    always_comb begin
        res           = '0;
        res.kind      = r_s1.kind;
        res.record_id = r_s1.id;
        case (r_s1.code)
            rsi_pkg::OP_RECORD: begin
                res.payload_offset  = r_s1.offset;
                res.payload_size    = r_s1.size;
                res.id_total_bytes  = tot_n;
                res.id_record_count = cnt_n;
                res.block_end       = r_s1.last;
            end
            rsi_pkg::OP_QUERY: begin
                if (r_s1.in_range) begin
                    res.id_total_bytes  = tot;
                    res.id_record_count = cnt;
                end
            end
            default: begin
                res.payload_offset = r_s1.offset;
                res.block_end      = r_s1.last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (o_free) begin
                r_s1_v <= i_op_valid;
            end
            if (s1_go) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (rd_en) begin
                r_byp <= wr && (i_op.id[AW-1:0] == r_s1.id[AW-1:0]);
            end
        end
        if (take) begin
            r_s1 <= i_op;
        end
        if (s1_go) begin
            r_out <= res;
        end
        // hold the written-back value while the next request waits in the stage
        if (wr) begin
            r_byp_d <= {tot_n, cnt_n};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            st_mem[r_s1.id[AW-1:0]] <= {tot_n, cnt_n};
        end
        if (rd_en) begin
            r_rd     <= st_mem[i_op.id[AW-1:0]];
            r_rd_vld <= r_st_vld[i_op.id[AW-1:0]];
        end
    end

    // start of a block wins over a write-back in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_st_vld <= '0;
        end else if (wr) begin
            r_st_vld[r_s1.id[AW-1:0]] <= 1'b1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_byp_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_byp) |-> $past(wr))
        else $error("bypass without write-back");

    a_record_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.kind == rsi_pkg::KIND_RECORD)) |-> (r_out.id_record_count != 32'd0))
        else $error("record request with zero count");

endmodule

`default_nettype wire

>>> src/record_stream_indexer_core.sv
// ----------------------------------------------------------------------------
// record_stream_indexer_core
// Indexes the records of a measurement data block, one byte per request.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries load, data byte, query and
// start requests; output channel o_out_valid / i_out_stall carries results.
// Configuration (id length, data start, data length) is written through
// i_cfg_we / i_cfg_idx / i_cfg_wdata by the user only while the block is
// idle; the block itself does not enforce this. Results pass the update
// stage and output registers; the last byte of a record identifier first
// waits for the size table read. Throughput: one request per cycle while
// the output does not stall, but that byte stalls input during the read.
// Totals and counts live in a read-modify-write memory with a registered read;
// a write-back and a read of the same entry in the same cycle are bypassed.
// Reset clears the size table valid bits and all totals; the block is ready
// at once, no clearing pass is needed. A start request clears totals, counts
// and parser state but keeps the size table.
// When the receiver stalls, the output register holds its result; one more
// request can still be taken into the update stage before input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module record_stream_indexer_core #(
    parameter int MAX_IDS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [47:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    input  wire rsi_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output rsi_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);

    // identifiers are 8 bits wide on the load and query side
    localparam int DEPTH = (MAX_IDS > 256) ? 256 : MAX_IDS;
    localparam int AW    = $clog2(DEPTH);

    logic         op_valid;
    rsi_pkg::t_op op;
    logic         op_free;
    logic         clr;

    rsi_parse #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_op_free   (op_free),
        .o_op_valid  (op_valid),
        .o_op        (op),
        .o_clr       (clr)
    );

    rsi_stats #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .i_clr       (clr),
        .o_free      (op_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

>>> tb/sv/record_stream_indexer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_stream_indexer_core_tb
// Self-checking bench for the record stream indexer.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and driven by a clocked driver.
// Each accepted request is run through a local behavioral predictor whose
// results are queued and compared field by field against the output channel.
// Blocks are indexed under several id lengths, offsets and block lengths,
// with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module record_stream_indexer_core_tb;

    localparam int           NUM_IDS   = 256;
    localparam logic [47:0]  MASK48    = 48'hFFFF_FFFF_FFFF;
    localparam int           CYCLE_MAX = 300000;
    localparam int           DRAIN     = 10;

    typedef enum logic [1:0] {
        PARSE_ID,
        PARSE_LEN,
        PARSE_SKIP
    } t_parse;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_idx;
    logic [47:0]         cfg_wdata;
    logic                in_valid;
    rsi_pkg::t_in_item   in_data;
    logic                in_stall;
    logic                out_valid;
    rsi_pkg::t_out_item  out_data;
    logic                out_stall;

    record_stream_indexer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // predictor state
    logic          tbl_valid [NUM_IDS];
    logic          tbl_var   [NUM_IDS];
    logic [31:0]   tbl_size  [NUM_IDS];
    logic [47:0]   id_total  [NUM_IDS];
    logic [31:0]   id_count  [NUM_IDS];
    t_parse        parse_ph;
    int            field_cnt;
    logic [63:0]   id_acc;
    logic [31:0]   len_acc;
    logic [31:0]   skip_left;
    logic [47:0]   byte_pos;
    logic          sticky_err;
    logic [3:0]    reg_id_len;
    logic [47:0]   reg_start;
    logic [47:0]   reg_length;

    rsi_pkg::t_in_item   pending_reqs [$];
    rsi_pkg::t_out_item  expected_results [$];
    int            send_idle_pct;
    int            recv_idle_pct;
    int            mismatches;
    int            cycles = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic clear_block();
        for (int i = 0; i < NUM_IDS; i++) begin
            id_total[i] = '0;
            id_count[i] = '0;
        end
        parse_ph   = PARSE_ID;
        field_cnt  = 0;
        id_acc     = '0;
        len_acc    = '0;
        skip_left  = '0;
        byte_pos   = '0;
        sticky_err = 1'b0;
    endtask

    task automatic count_record(inout rsi_pkg::t_out_item r, input logic [7:0] id,
                                input logic [31:0] size, input logic [47:0] offset);
        logic [48:0] sum;
        sum = {1'b0, id_total[id]} + 49'(size);
        id_total[id] = sum[48] ? MASK48 : sum[47:0];
        if (id_count[id] != 32'hFFFF_FFFF)
            id_count[id] = id_count[id] + 1;
        r.kind            = rsi_pkg::KIND_RECORD;
        r.record_id       = id;
        r.payload_offset  = offset;
        r.payload_size    = size;
        r.id_total_bytes  = id_total[id];
        r.id_record_count = id_count[id];
        skip_left = size;
        parse_ph  = (size != 0) ? PARSE_SKIP : PARSE_ID;
        field_cnt = 0;
    endtask

    // Advances the predictor by one accepted request.
    task automatic index_request(input rsi_pkg::t_in_item it);
        rsi_pkg::t_out_item r;
        logic      has;
        logic      last;
        int        len;
        r   = '0;
        has = 1'b0;
        case (it.action)
            rsi_pkg::ACT_LOAD: begin
                tbl_valid[it.entry_id] = 1'b1;
                tbl_var[it.entry_id]   = it.entry_variable;
                tbl_size[it.entry_id]  = it.entry_size;
            end
            rsi_pkg::ACT_QUERY: begin
                has               = 1'b1;
                r.kind            = rsi_pkg::KIND_QUERY;
                r.record_id       = it.entry_id;
                r.id_total_bytes  = id_total[it.entry_id];
                r.id_record_count = id_count[it.entry_id];
            end
            rsi_pkg::ACT_START: clear_block();
            default: begin
                if (!sticky_err && byte_pos < reg_length) begin
                    byte_pos    = byte_pos + 1;
                    last        = (byte_pos == reg_length);
                    r.block_end = last;
                    if (parse_ph == PARSE_ID) begin
                        len = (reg_id_len < 1) ? 1 : ((reg_id_len > 8) ? 8 : reg_id_len);
                        if (field_cnt == 0)
                            id_acc = '0;
                        id_acc    = id_acc | (64'(it.data_byte) << (8 * field_cnt));
                        field_cnt = field_cnt + 1;
                        if (field_cnt < len) begin
                            if (last) begin
                                has    = 1'b1;
                                r.kind = rsi_pkg::KIND_TRUNC;
                            end
                        end else begin
                            field_cnt = 0;
                            if (id_acc >= NUM_IDS || !tbl_valid[id_acc[7:0]]) begin
                                sticky_err       = 1'b1;
                                has              = 1'b1;
                                r.kind           = rsi_pkg::KIND_UNKNOWN;
                                r.record_id      = id_acc[7:0];
                                r.payload_offset = reg_start + byte_pos;
                            end else if (tbl_var[id_acc[7:0]]) begin
                                parse_ph = PARSE_LEN;
                                len_acc  = '0;
                                if (last) begin
                                    has         = 1'b1;
                                    r.kind      = rsi_pkg::KIND_TRUNC;
                                    r.record_id = id_acc[7:0];
                                end
                            end else begin
                                has = 1'b1;
                                count_record(r, id_acc[7:0], tbl_size[id_acc[7:0]],
                                             reg_start + byte_pos);
                            end
                        end
                    end else if (parse_ph == PARSE_LEN) begin
                        len_acc   = len_acc | (32'(it.data_byte) << (8 * field_cnt));
                        field_cnt = field_cnt + 1;
                        if (field_cnt < 4) begin
                            if (last) begin
                                has         = 1'b1;
                                r.kind      = rsi_pkg::KIND_TRUNC;
                                r.record_id = id_acc[7:0];
                            end
                        end else begin
                            has = 1'b1;
                            count_record(r, id_acc[7:0], len_acc,
                                         reg_start + byte_pos - rsi_pkg::LEN_BYTES);
                        end
                    end else begin
                        if (skip_left > 0)
                            skip_left = skip_left - 1;
                        if (skip_left == 0)
                            parse_ph = PARSE_ID;
                        if (last) begin
                            has    = 1'b1;
                            r.kind = rsi_pkg::KIND_END;
                        end
                    end
                end
            end
        endcase
        if (has)
            expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                index_request(in_data);
            if (!in_valid || !in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rsi_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result kind", 64'(out_data.kind), 64'hx);
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.kind !== want.kind)
                        report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
                    if (out_data.record_id !== want.record_id)
                        report_mismatch("record_id", 64'(out_data.record_id),
                                        64'(want.record_id));
                    if (out_data.payload_offset !== want.payload_offset)
                        report_mismatch("payload_offset", 64'(out_data.payload_offset),
                                        64'(want.payload_offset));
                    if (out_data.payload_size !== want.payload_size)
                        report_mismatch("payload_size", 64'(out_data.payload_size),
                                        64'(want.payload_size));
                    if (out_data.id_total_bytes !== want.id_total_bytes)
                        report_mismatch("id_total_bytes", 64'(out_data.id_total_bytes),
                                        64'(want.id_total_bytes));
                    if (out_data.id_record_count !== want.id_record_count)
                        report_mismatch("id_record_count", 64'(out_data.id_record_count),
                                        64'(want.id_record_count));
                    if (out_data.block_end !== want.block_end)
                        report_mismatch("block_end", 64'(out_data.block_end),
                                        64'(want.block_end));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] act, input logic [7:0] b,
                            input logic [7:0] id, input logic [31:0] size,
                            input logic var_len);
        rsi_pkg::t_in_item it;
        it.action         = act;
        it.data_byte      = b;
        it.entry_id       = id;
        it.entry_size     = size;
        it.entry_variable = var_len;
        pending_reqs.push_back(it);
    endtask

    // fields that an action ignores get random content
    task automatic push_byte(input logic [7:0] b);
        push_req(rsi_pkg::ACT_BYTE, b, 8'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic push_query(input logic [7:0] id);
        push_req(rsi_pkg::ACT_QUERY, 8'($urandom), id, $urandom, 1'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            rsi_pkg::CFG_ID_LENGTH:  reg_id_len = value[3:0];
            rsi_pkg::CFG_DATA_START: reg_start  = value;
            default:                 reg_length = value;
        endcase
    endtask

    task automatic set_block(input logic [3:0] id_len, input logic [47:0] start,
                             input logic [47:0] length);
        wait_idle();
        write_reg(rsi_pkg::CFG_ID_LENGTH, 48'(id_len));
        write_reg(rsi_pkg::CFG_DATA_START, start);
        write_reg(rsi_pkg::CFG_DATA_LENGTH, length);
    endtask

    // Mostly well-formed records of loaded ids, plus queries, noise and bad ids.
    task automatic gen_records(input int n_items, input bit with_start);
        logic [7:0]  ids  [8];
        logic        vars [8];
        logic [31:0] lens [8];
        int          base;
        int          k;
        int          sel;
        int          idl;
        logic [31:0] vlen;
        base = pending_reqs.size();
        idl  = (reg_id_len < 1) ? 1 : ((reg_id_len > 8) ? 8 : reg_id_len);
        if (with_start)
            push_req(rsi_pkg::ACT_START, 8'($urandom), 8'($urandom), $urandom,
                     1'($urandom));
        for (int i = 0; i < 8; i++) begin
            ids[i]  = 8'($urandom);
            vars[i] = 1'($urandom);
            lens[i] = ($urandom_range(7) == 0) ? $urandom : $urandom_range(6);
            push_req(rsi_pkg::ACT_LOAD, 8'($urandom), ids[i], lens[i], vars[i]);
        end
        while (pending_reqs.size() - base < n_items) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                push_query(($urandom_range(1) == 0) ? ids[$urandom_range(7)] : 8'($urandom));
            end else if (sel < 8) begin
                push_byte(8'($urandom));
            end else if (sel < 10) begin
                for (int j = 0; j < idl; j++)
                    push_byte(8'($urandom));
            end else begin
                k = $urandom_range(7);
                push_byte(ids[k]);
                for (int j = 1; j < idl; j++)
                    push_byte(($urandom_range(30) == 0) ? 8'($urandom) : 8'h00);
                vlen = lens[k];
                if (vars[k]) begin
                    vlen = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
                    for (int j = 0; j < 4; j++)
                        push_byte(vlen[8*j +: 8]);
                end
                for (int j = 0; j < vlen && j < 12; j++)
                    push_byte(8'($urandom));
            end
        end
        for (int i = 0; i < 8; i++)
            push_query(ids[i]);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 50;
        mismatches    = 0;
        for (int i = 0; i < NUM_IDS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_var[i]   = 1'b0;
            tbl_size[i]  = '0;
        end
        reg_id_len = 4'd1;
        reg_start  = '0;
        reg_length = '0;
        clear_block();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty block: bytes are dropped, queries still answer
        set_block(4'd0, 48'd0, 48'd0);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_query(8'h00);
        push_query(8'hFF);
        push_req(rsi_pkg::ACT_LOAD, 8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        push_req(rsi_pkg::ACT_LOAD, 8'hFF, 8'h00, 32'h0, 1'b0);
        push_req(rsi_pkg::ACT_LOAD, 8'h00, 8'h01, 32'h2, 1'b0);

        // offsets wrap at the top; zero-size record, variable record cut in its length
        set_block(4'd1, MASK48 - 48'd2, 48'd7);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hAA);
        push_byte(8'h55);
        push_byte(8'hFF);
        push_byte(8'h10);
        push_byte(8'h20);
        push_byte(8'h30);
        push_query(8'h01);
        push_query(8'hFF);

        // unknown id sets the sticky error, later bytes dropped
        set_block(4'd1, 48'd100, 48'd6);
        push_byte(8'h00);
        push_byte(8'h77);
        push_byte(8'h01);
        push_query(8'h00);
        push_req(rsi_pkg::ACT_START, 8'h00, 8'h00, 32'h0, 1'b0);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h03);
        push_byte(8'h00);

        set_block(4'd1, 48'($urandom), 48'd80);
        gen_records(80, 1'b1);
        set_block(4'd2, MASK48 - 48'd20, 48'd90);
        gen_records(80, 1'b1);

        send_idle_pct = 50;
        recv_idle_pct = 12;
        set_block(4'd8, {16'($urandom), 32'($urandom)}, 48'd150);
        gen_records(60, 1'b1);
        wait_idle();
        gen_records(60, 1'b0);
        set_block(4'd15, 48'd0, 48'd100);
        gen_records(80, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_block(4'd3, 48'($urandom), MASK48);
        gen_records(80, 1'b1);
        set_block(4'd4, 48'($urandom), 48'd70);
        gen_records(80, 1'b1);

        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
src/rsi_pkg.sv
src/rsi_parse.sv
src/rsi_stats.sv
src/record_stream_indexer_core.sv
tb/sv/record_stream_indexer_core_tb.sv
